FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// each expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efr check failed: same-cycle implication");

// next-cycle implication
`define EFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efr check failed: next-cycle implication");

`endif

FILE: rtl/efr_pkg.sv
package efr_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int FILL_W = 7;
  localparam int CNT_W  = 16;
  localparam int KIND_W = 2;
  localparam int CODE_W = 2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [CODE_W-1:0] ERR_START    = 2'd0;
  localparam logic [CODE_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [CODE_W-1:0] ERR_ESCAPE   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_START    = 2'd1;
  localparam logic [1:0] REG_END      = 2'd2;
  localparam logic [1:0] REG_ESCAPE   = 2'd3;

  // reset values of the registers
  localparam logic [FILL_W-1:0] CAPACITY_RST = 7'd64;
  localparam logic [BYTE_W-1:0] START_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] END_RST      = 8'd4;
  localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'd27;

  // controller to datapath
  typedef struct packed {
    logic              store;
    logic              fill_clr;
    logic              cnt_inc;
    logic              rd_first;
    logic              rd_next;
    logic              push;
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] code;
  } efr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_start;
    logic is_end;
    logic is_esc;
    logic full;
    logic fill_zero;
    logic rd_last;
    logic out_free;
  } efr_sts_t;

endpackage

FILE: rtl/escaped_frame_receiver_unit.sv
// channel   dir  handshake                        payload
// in        in   in_valid / in_ready              in_rx_byte
// out       out  out_valid / out_ready            kind, payload, frame_length, last,
//                                                 fault_code, error_total
// cfg       in   psel / penable / pwrite, pready  paddr, pwdata, prdata
//
// plain bytes and control bytes that give no word are taken in the idle state
// an error or an empty frame is accepted, then gives one output push
// a frame end is accepted, then gives one output push per stored byte, paced by the
// registered read port of the frame buffer feeding the single output register
// rst_n is synchronous; it restores the register defaults and clears phase,
// fill count and error counter; buffer contents are not cleared
// a stalled output holds the controller in its push, error or empty state with in_ready low
module escaped_frame_receiver_unit import efr_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_payload,
  output logic [FILL_W-1:0] out_frame_length,
  output logic              out_last,
  output logic [CODE_W-1:0] out_fault_code,
  output logic [CNT_W-1:0]  out_error_total,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  efr_cmd_t cmd;
  efr_sts_t sts;
  logic     cfg_we;

  // apb write strobe, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  efr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  efr_dp #(
    .FRAME_DEPTH (FRAME_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_rx_byte       (in_rx_byte),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_idx          (paddr[3:2]),
    .cfg_wdata        (pwdata),
    .cfg_rdata        (prdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_payload      (out_payload),
    .out_frame_length (out_frame_length),
    .out_last         (out_last),
    .out_fault_code   (out_fault_code),
    .out_error_total  (out_error_total)
  );

endmodule

FILE: rtl/efr_ram.sv
module efr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/efr_ctrl.sv
module efr_ctrl import efr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  efr_sts_t sts,
  output efr_cmd_t cmd
);

  // controller states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ERR   = 2'd1;
  localparam logic [1:0] S_EMPTY = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  // receive phases
  localparam logic [1:0] PH_WAIT  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_ESC   = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              try_store;
  logic              raise;
  logic [CODE_W-1:0] raise_code;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    cmd        = '0;
    try_store  = 1'b0;
    raise      = 1'b0;
    raise_code = ERR_START;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (phase_r)
            PH_WAIT: begin
              if (sts.is_start) begin
                phase_nxt = PH_FRAME;
              end
            end
            PH_FRAME: begin
              if (sts.is_start) begin
                phase_nxt  = PH_WAIT;
                raise      = 1'b1;
                raise_code = ERR_START;
              end else if (sts.is_end) begin
                phase_nxt = PH_WAIT;
                if (sts.fill_zero) begin
                  state_nxt = S_EMPTY;
                end else begin
                  cmd.rd_first = 1'b1;
                  state_nxt    = S_PUSH;
                end
              end else if (sts.is_esc) begin
                phase_nxt = PH_ESC;
              end else begin
                try_store = 1'b1;
              end
            end
            PH_ESC: begin
              if (sts.is_start || sts.is_end || sts.is_esc) begin
                phase_nxt = PH_FRAME;
                try_store = 1'b1;
              end else begin
                raise      = 1'b1;
                raise_code = ERR_ESCAPE;
              end
            end
            default: ;
          endcase
          // store attempt, overflow drops the byte
          if (try_store) begin
            if (sts.full) begin
              raise      = 1'b1;
              raise_code = ERR_OVERFLOW;
            end else begin
              cmd.store = 1'b1;
            end
          end
          if (raise) begin
            cmd.fill_clr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            code_nxt     = raise_code;
            state_nxt    = S_ERR;
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          cmd.kind  = KIND_ERROR;
          cmd.code  = code_r;
          state_nxt = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          cmd.kind  = KIND_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      S_PUSH: begin
        if (sts.out_free) begin
          cmd.push = 1'b1;
          cmd.kind = KIND_BYTE;
          if (sts.rd_last) begin
            cmd.fill_clr = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_WAIT;
      code_r  <= ERR_START;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

FILE: rtl/efr_dp.sv
module efr_dp import efr_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  efr_cmd_t          cmd,
  output efr_sts_t          sts,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  output logic [31:0]       cfg_rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [BYTE_W-1:0] out_payload,
  output logic [FILL_W-1:0] out_frame_length,
  output logic              out_last,
  output logic [CODE_W-1:0] out_fault_code,
  output logic [CNT_W-1:0]  out_error_total
);

  localparam int IW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam logic [FILL_W-1:0] DEPTH_C = FILL_W'(FRAME_DEPTH);

  logic [FILL_W-1:0] cap_r;
  logic [BYTE_W-1:0] start_r, end_r, esc_r;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [FILL_W-1:0] cap_eff;
  logic              ram_re;
  logic [IW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r;
  logic [BYTE_W-1:0] out_payload_r;
  logic [FILL_W-1:0] out_len_r;
  logic              out_last_r;
  logic [CODE_W-1:0] out_code_r;
  logic [CNT_W-1:0]  out_total_r;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAPACITY_RST;
      start_r <= START_RST;
      end_r   <= END_RST;
      esc_r   <= ESCAPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CAPACITY: cap_r   <= cfg_wdata[FILL_W-1:0];
        REG_START:    start_r <= cfg_wdata[BYTE_W-1:0];
        REG_END:      end_r   <= cfg_wdata[BYTE_W-1:0];
        REG_ESCAPE:   esc_r   <= cfg_wdata[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_CAPACITY: cfg_rdata = 32'(cap_r);
      REG_START:    cfg_rdata = 32'(start_r);
      REG_END:      cfg_rdata = 32'(end_r);
      REG_ESCAPE:   cfg_rdata = 32'(esc_r);
      default:      cfg_rdata = '0;
    endcase
  end

  // capacity limited to the buffer depth
  assign cap_eff = (cap_r > DEPTH_C) ? DEPTH_C : cap_r;

  // status toward the controller
  assign sts.is_start  = (in_rx_byte == start_r);
  assign sts.is_end    = (in_rx_byte == end_r);
  assign sts.is_esc    = (in_rx_byte == esc_r);
  assign sts.full      = (fill_r >= cap_eff);
  assign sts.fill_zero = (fill_r == '0);
  assign sts.rd_last   = ((FILL_W'(rd_idx_r) + FILL_W'(1)) == fill_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // fill count, error counter, readout index
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.fill_clr) begin
      fill_nxt = '0;
    end else if (cmd.store) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    cnt_nxt = cnt_r;
    if (cmd.cnt_inc && (cnt_r != {CNT_W{1'b1}})) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_first) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_next) begin
      rd_idx_nxt = rd_idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cnt_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
    end
  end

  // frame buffer, read data holds while the output stalls
  assign ram_re    = cmd.rd_first || cmd.rd_next;
  assign ram_raddr = cmd.rd_first ? '0 : rd_idx_r + IW'(1);

  efr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (fill_r[IW-1:0]),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_kind_r    <= cmd.kind;
      out_payload_r <= (cmd.kind == KIND_BYTE) ? ram_rdata : '0;
      out_len_r     <= (cmd.kind == KIND_ERROR) ? '0 : fill_r;
      out_last_r    <= (cmd.kind != KIND_BYTE) || sts.rd_last;
      out_code_r    <= (cmd.kind == KIND_ERROR) ? cmd.code : ERR_START;
      out_total_r   <= cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_payload      = out_payload_r;
  assign out_frame_length = out_len_r;
  assign out_last         = out_last_r;
  assign out_fault_code   = out_code_r;
  assign out_error_total  = out_total_r;

endmodule

FILE: rtl/efr_checker.sv
`include "assert_macros.svh"

module efr_checker import efr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [BYTE_W-1:0] out_payload,
  input logic [FILL_W-1:0] out_frame_length,
  input logic              out_last,
  input logic [CODE_W-1:0] out_fault_code,
  input logic [CNT_W-1:0]  out_error_total
);

  // a stalled word holds
  `EFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload) && $stable(out_kind) && $stable(out_error_total))

  // an error word is a lone last word with no payload
  `EFR_ASSERT_IMPL(a_err_word, out_valid && (out_kind == KIND_ERROR), out_last && (out_payload == '0) && (out_frame_length == '0) && (out_error_total != '0))

  // only error words carry a code
  `EFR_ASSERT_IMPL(a_code_zero, out_valid && (out_kind != KIND_ERROR), out_fault_code == ERR_START)

  // an empty frame word is last, with zero length
  `EFR_ASSERT_IMPL(a_empty_word, out_valid && (out_kind == KIND_EMPTY), out_last && (out_frame_length == '0) && (out_payload == '0))

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kind         (out_kind),
  .out_payload      (out_payload),
  .out_frame_length (out_frame_length),
  .out_last         (out_last),
  .out_fault_code   (out_fault_code),
  .out_error_total  (out_error_total)
);
